>>> hdl/uoq_pkg.sv
// Shared types and constants for the ultrasonic occupancy qualifier.
// Used by uoq_eval and by the top level; depends on nothing else.
package uoq_pkg;

	localparam int unsigned ECHO_W   = 15;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned DIST_W   = 9;
	localparam int unsigned THR_W    = 8;
	localparam int unsigned DELAY_W  = 16;
	localparam int unsigned NEED_W   = 26;
	localparam int unsigned SENSOR_W = 4;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [ECHO_W-1:0] ECHO_MAX_US = 15'd30000;
	localparam logic [DIST_W-1:0] DIST_MIN_CM = 9'd2;
	localparam logic [DIST_W-1:0] DIST_MAX_CM = 9'd400;
	localparam logic [DIST_W-1:0] DIST_FAR_CM = 9'd401;
	localparam logic [9:0]        MS_PER_S    = 10'd1000;

	// echo_us * 343 / 20000 is done as one multiply by a scaled reciprocal.
	// The rounding error stays below one part in 20000 over the 15-bit input.
	localparam int unsigned       DIST_SHIFT = 30;
	localparam logic [24:0]       DIST_RECIP = 25'd18414673;

	localparam logic [THR_W-1:0] THR_RESET = 8'd100;
	localparam logic [THR_W-1:0] THR_MIN   = 8'd1;
	localparam logic [THR_W-1:0] THR_MAX   = 8'd254;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_VACATE    = 2'd1,
		CFG_ARRIVE    = 2'd2,
		CFG_UNUSED    = 2'd3
	} uoq_cfg_idx_t;

	typedef struct packed {
		logic [TIME_W-1:0]   now_ms;
		logic [ECHO_W-1:0]   echo_us;
		logic                echo_started;
		logic [SENSOR_W-1:0] sensor;
	} uoq_item_t;

	typedef struct packed {
		logic                changed;
		logic                reported_occupied;
		logic                raw_occupied;
		logic [DIST_W-1:0]   range_cm;
		logic                reading_ok;
		logic [SENSOR_W-1:0] sensor_out;
	} uoq_result_t;

	typedef struct packed {
		logic [TIME_W-1:0] change_time;
		logic              reported;
		logic              raw;
	} uoq_entry_t;

	typedef struct packed {
		logic [NEED_W-1:0] arrive_need;
		logic [NEED_W-1:0] vacate_need;
		logic [THR_W-1:0]  threshold;
	} uoq_cfg_t;

endpackage

>>> hdl/uoq_eval.sv
// Per-item evaluation: distance, validity, raw and delay-qualified occupancy.
// Purely combinational; depends on uoq_pkg.
module uoq_eval
	import uoq_pkg::*;
(
	input  uoq_item_t   item,
	input  logic        in_range,
	input  uoq_entry_t  entry,
	input  uoq_cfg_t    cfg,
	output uoq_result_t result,
	output uoq_entry_t  entry_next
);

	logic [39:0]         prod;
	logic [9:0]          dist_raw;
	logic                too_long;
	logic                in_window;
	logic                ok;
	logic [DIST_W-1:0]   dist_far;
	logic                det;
	logic                raw_flip;
	logic                raw_n;
	logic [TIME_W-1:0]   time_n;
	logic [TIME_W-1:0]   elapsed;
	logic [NEED_W-1:0]   need;
	logic                fire;

	assign prod      = 40'(item.echo_us) * 40'(DIST_RECIP);
	assign dist_raw  = prod[DIST_SHIFT +: 10];
	assign too_long  = item.echo_us > ECHO_MAX_US;
	assign in_window = (dist_raw >= 10'(DIST_MIN_CM)) && (dist_raw <= 10'(DIST_MAX_CM));
	assign ok        = in_range && item.echo_started && (too_long || in_window);
	assign dist_far  = too_long ? DIST_FAR_CM : dist_raw[DIST_W-1:0];
	assign det       = dist_far <= DIST_W'(cfg.threshold);

	// A change of raw state restarts the hold timer at this item's time.
	assign raw_flip = ok && (det != entry.raw);
	assign raw_n    = raw_flip ? det : entry.raw;
	assign time_n   = raw_flip ? item.now_ms : entry.change_time;
	assign elapsed  = item.now_ms - time_n;
	assign need     = raw_n ? cfg.arrive_need : cfg.vacate_need;
	assign fire     = ok && (raw_n != entry.reported) && (elapsed >= TIME_W'(need));

	always_comb begin
		entry_next.raw         = raw_n;
		entry_next.change_time = time_n;
		entry_next.reported    = fire ? raw_n : entry.reported;

		result.sensor_out        = item.sensor;
		result.reading_ok        = ok;
		result.range_cm          = ok ? dist_far : '0;
		result.raw_occupied      = raw_n;
		result.reported_occupied = entry_next.reported;
		result.changed           = fire;
	end

endmodule

>>> hdl/ultrasonic_occupancy_qualifier_core.sv
// Ultrasonic occupancy qualifier, top level.
// Depends on uoq_pkg and uoq_eval.
//
// Each input item is one echo measurement for one sensor. The block turns it
// into a distance, updates that sensor's raw occupancy and change time, and
// promotes the raw state to the reported state once it has held for the
// arrive or vacate delay. Exactly one result item comes out per input item,
// in order.
//
// Input stream: s_tvalid/s_tready/s_tdata/s_tuser. Output stream: m_tvalid/m_tready/
// m_tdata/m_tuser. Configuration: cfg_we/cfg_index/cfg_data, written by the user only
// while no item is in flight, not enforced by the block; unknown indexes are ignored.
//
// A result passes an input register, then the evaluation logic, then the result
// register. Throughput is one item per cycle while the receiver keeps up; the
// per-sensor state is written on the same edge as the result register, so an
// item for the same sensor in the next cycle sees the update.
// When the receiver stalls, the result register holds and one more item waits
// in the input register; s_tready then drops.
// Reset clears all sensor state to unoccupied with change time zero, and sets
// threshold 100 cm and both delays to zero.
module ultrasonic_occupancy_qualifier_core
	import uoq_pkg::*;
#(
	parameter int unsigned SENSORS = 16
)(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// s_tdata: echo_started [0], echo_us [15:1], now_ms [47:16]
	input  logic [47:0]          s_tdata,
	// s_tuser: sensor [3:0]
	input  logic [3:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// m_tdata: reading_ok [0], range_cm [9:1], raw_occupied [10],
	// reported_occupied [11], changed [12], zero [15:13]
	output logic [15:0]          m_tdata,
	// m_tuser: sensor_out [3:0]
	output logic [3:0]           m_tuser,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DELAY_W-1:0]   cfg_data
);

	// Only sensor numbers that the 4-bit field can carry need storage.
	localparam int unsigned NUM   = (SENSORS < 16) ? SENSORS : 16;
	localparam int unsigned IDX_W = (NUM > 1) ? $clog2(NUM) : 1;

	uoq_cfg_t    cfg_q;
	uoq_item_t   item_s1;
	logic        valid_s1;
	uoq_result_t result_s2;
	logic        valid_s2;

	logic              raw_q  [NUM];
	logic              rep_q  [NUM];
	logic [TIME_W-1:0] time_q [NUM];

	logic        adv;
	logic        in_range;
	logic [IDX_W-1:0] idx;
	uoq_entry_t  entry_rd;
	uoq_entry_t  entry_next;
	uoq_result_t result_c;
	logic [THR_W-1:0] thr_sat;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	assign in_range = {4'b0, item_s1.sensor} < 8'(NUM);
	assign idx      = IDX_W'(item_s1.sensor);

	always_comb begin
		if (in_range) begin
			entry_rd.raw         = raw_q[idx];
			entry_rd.reported    = rep_q[idx];
			entry_rd.change_time = time_q[idx];
		end else begin
			entry_rd = '0;
		end
	end

	uoq_eval u_eval (
		.item       (item_s1),
		.in_range   (in_range),
		.entry      (entry_rd),
		.cfg        (cfg_q),
		.result     (result_c),
		.entry_next (entry_next)
	);

	always_comb begin
		thr_sat = cfg_data[THR_W-1:0];
		if (thr_sat < THR_MIN) begin
			thr_sat = THR_MIN;
		end else if (thr_sat > THR_MAX) begin
			thr_sat = THR_MAX;
		end
	end

	// The delays are kept in milliseconds so the item path only subtracts and compares.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold   <= THR_RESET;
			cfg_q.vacate_need <= '0;
			cfg_q.arrive_need <= '0;
		end else if (cfg_we) begin
			unique case (uoq_cfg_idx_t'(cfg_index))
				CFG_THRESHOLD: cfg_q.threshold   <= thr_sat;
				CFG_VACATE:    cfg_q.vacate_need <= NEED_W'(cfg_data) * NEED_W'(MS_PER_S);
				CFG_ARRIVE:    cfg_q.arrive_need <= NEED_W'(cfg_data) * NEED_W'(MS_PER_S);
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.sensor       <= s_tuser;
			item_s1.echo_started <= s_tdata[0];
			item_s1.echo_us      <= s_tdata[15:1];
			item_s1.now_ms       <= s_tdata[47:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s2 <= result_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM; i++) begin
				raw_q[i]  <= 1'b0;
				rep_q[i]  <= 1'b0;
				time_q[i] <= '0;
			end
		end else if (adv && in_range) begin
			raw_q[idx]  <= entry_next.raw;
			rep_q[idx]  <= entry_next.reported;
			time_q[idx] <= entry_next.change_time;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = result_s2.sensor_out;
	assign m_tdata  = {3'b000, result_s2.changed, result_s2.reported_occupied,
		result_s2.raw_occupied, result_s2.range_cm, result_s2.reading_ok};

endmodule

>>> bench/tb.sv
// Self-checking bench for ultrasonic_occupancy_qualifier_core: directed probes, then
// random measurements over several register settings, each result checked against a
// typed value or an occupancy predictor. Depends on uoq_pkg and the core RTL only.
module tb;
	import uoq_pkg::*;

	localparam int NUM_SENSORS = 16;
	localparam int ITEMS_PER_PHASE = 170;
	localparam int QUIET_LIMIT = 2000;
	localparam int unsigned SOUND_NUM = 343;
	localparam int unsigned SOUND_DEN = 20000;
	localparam logic [ECHO_W-1:0] ECHO_MIN_OK = 15'd117;
	localparam logic [ECHO_W-1:0] ECHO_MAX_OK = 15'd23381;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [47:0]          s_tdata = '0;
	logic [3:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [15:0]          m_tdata;
	logic [3:0]           m_tuser;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DELAY_W-1:0]   cfg_data = '0;

	typedef struct {
		uoq_item_t   stim;
		bit          typed;
		uoq_result_t res;
	} probe_t;

	// Predictor copy of the registers and of the per-sensor state.
	logic [THR_W-1:0]   thr_cm = THR_RESET;
	logic [DELAY_W-1:0] vacate_s = '0;
	logic [DELAY_W-1:0] arrive_s = '0;
	logic               raw_occ [NUM_SENSORS];
	logic               rep_occ [NUM_SENSORS];
	logic [TIME_W-1:0]  raw_since [NUM_SENSORS];

	uoq_result_t  pending_reports [$];
	probe_t       probes [$];
	bit           typed_now = 1'b0;
	uoq_result_t  typed_res = '0;
	bit           src_idle_en = 1'b1;
	bit           snk_idle_en = 1'b1;
	logic [31:0]  now_base = 32'hFFFF_0000;
	int           mismatches = 0;
	int           quiet_cycles = 0;

	ultrasonic_occupancy_qualifier_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic uoq_result_t occupancy_step(uoq_item_t it);
		uoq_result_t r;
		logic [31:0] span;
		logic [31:0] need;
		logic [31:0] elapsed;
		logic        ok;
		logic        det;
		int          s;
		r = '0;
		s = it.sensor;
		span = '0;
		ok = 1'b0;
		r.sensor_out = it.sensor;
		if (!it.echo_started) begin
			ok = 1'b0;
		end else if (it.echo_us > ECHO_MAX_US) begin
			ok = 1'b1;
			span = 32'(DIST_FAR_CM);
		end else begin
			span = (32'(it.echo_us) * SOUND_NUM) / SOUND_DEN;
			ok = (span >= 32'(DIST_MIN_CM)) && (span <= 32'(DIST_MAX_CM));
			if (!ok)
				span = '0;
		end
		if (ok) begin
			det = (span <= 32'(thr_cm));
			if (det != raw_occ[s]) begin
				raw_occ[s] = det;
				raw_since[s] = it.now_ms;
			end
			if (raw_occ[s] != rep_occ[s]) begin
				need = 32'(raw_occ[s] ? arrive_s : vacate_s) * 32'(MS_PER_S);
				elapsed = it.now_ms - raw_since[s];
				if (elapsed >= need) begin
					rep_occ[s] = raw_occ[s];
					r.changed = 1'b1;
				end
			end
		end
		r.reading_ok = ok;
		r.range_cm = span[DIST_W-1:0];
		r.raw_occupied = raw_occ[s];
		r.reported_occupied = rep_occ[s];
		return r;
	endfunction

	function automatic void add_probe(logic [3:0] s, logic st, logic [14:0] e, logic [31:0] t,
			bit typed, logic ok, logic [8:0] d, logic raw, logic rep, logic chg);
		probe_t p;
		p.stim.sensor = s;
		p.stim.echo_started = st;
		p.stim.echo_us = e;
		p.stim.now_ms = t;
		p.typed = typed;
		p.res.sensor_out = s;
		p.res.reading_ok = ok;
		p.res.range_cm = d;
		p.res.raw_occupied = raw;
		p.res.reported_occupied = rep;
		p.res.changed = chg;
		probes.push_back(p);
	endfunction

	// Random measurement: mostly valid echoes, many around the current threshold, some far
	// readings, some errors, and a little raw noise in every field.
	function automatic uoq_item_t make_item();
		uoq_item_t it;
		int        r;
		int        w_thr;
		int        lo;
		r = $urandom_range(0, 99);
		w_thr = int'(thr_cm) * SOUND_DEN / SOUND_NUM;
		lo = (w_thr > 517) ? w_thr - 400 : 117;
		now_base += ($urandom_range(0, 99) < 5) ? $urandom_range(0, 70000) : $urandom_range(0, 1500);
		it.sensor = ($urandom_range(0, 99) < 60) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
		it.echo_started = ($urandom_range(0, 99) < 94);
		it.now_ms = ($urandom_range(0, 99) < 6) ? $urandom : now_base;
		if (r < 35)
			it.echo_us = 15'($urandom_range(ECHO_MIN_OK, ECHO_MAX_OK));
		else if (r < 65)
			it.echo_us = 15'($urandom_range(lo, w_thr + 400));
		else if (r < 78)
			it.echo_us = 15'($urandom_range(30001, 32767));
		else if (r < 88)
			it.echo_us = $urandom_range(0, 1) ? 15'($urandom_range(0, 116))
				: 15'($urandom_range(23382, 30000));
		else
			it.echo_us = 15'($urandom);
		return it;
	endfunction

	// Entered and left just after a falling edge.
	task automatic send_item(uoq_item_t it, bit typed, uoq_result_t res);
		while (src_idle_en && $urandom_range(0, 99) < 10) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		{s_tdata, s_tuser} <= it;
		typed_now <= typed;
		typed_res <= res;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain_reports(int settle);
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_reg(uoq_cfg_idx_t idx, logic [DELAY_W-1:0] data);
		logic [THR_W-1:0] thr;
		thr = data[THR_W-1:0];
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_THRESHOLD: begin
				if (thr < THR_MIN)
					thr = THR_MIN;
				if (thr > THR_MAX)
					thr = THR_MAX;
				thr_cm = thr;
			end
			CFG_VACATE: vacate_s = data;
			CFG_ARRIVE: arrive_s = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	always @(negedge clk)
		m_tready <= !(snk_idle_en && $urandom_range(0, 99) < 10);

	always @(posedge clk) begin
		uoq_item_t   acc;
		uoq_result_t pred;
		uoq_result_t got;
		uoq_result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				acc = {s_tdata, s_tuser};
				pred = occupancy_step(acc);
				pending_reports.push_back(typed_now ? typed_res : pred);
			end
			if (m_tvalid && m_tready) begin
				got = {m_tdata[12:0], m_tuser};
				if (pending_reports.size() == 0) begin
					$error("result with nothing expected: sensor_out %0d", got.sensor_out);
					mismatches++;
				end else begin
					want = pending_reports.pop_front();
					if (got.sensor_out != want.sensor_out) begin
						$error("sensor_out: expected %0d, actual %0d", want.sensor_out,
							got.sensor_out);
						mismatches++;
					end
					if (got.reading_ok != want.reading_ok) begin
						$error("reading_ok: expected %0d, actual %0d", want.reading_ok,
							got.reading_ok);
						mismatches++;
					end
					if (got.range_cm != want.range_cm) begin
						$error("range_cm: expected %0d, actual %0d", want.range_cm,
							got.range_cm);
						mismatches++;
					end
					if (got.raw_occupied != want.raw_occupied) begin
						$error("raw_occupied: expected %0d, actual %0d", want.raw_occupied,
							got.raw_occupied);
						mismatches++;
					end
					if (got.reported_occupied != want.reported_occupied) begin
						$error("reported_occupied: expected %0d, actual %0d",
							want.reported_occupied, got.reported_occupied);
						mismatches++;
					end
					if (got.changed != want.changed) begin
						$error("changed: expected %0d, actual %0d", want.changed, got.changed);
						mismatches++;
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet_cycles <= 0;
			else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("** ultrasonic_occupancy_qualifier_core: FAILED **");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		uoq_item_t it;
		for (int k = 0; k < NUM_SENSORS; k++) begin
			raw_occ[k] = 1'b0;
			rep_occ[k] = 1'b0;
			raw_since[k] = '0;
		end

		// Reset defaults: threshold 100 cm, both delays zero, so a valid reading is
		// reported on the item that changes the raw state.
		add_probe(4'd0, 1'b0, 15'd500, 32'd0, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0, 1'b0);
		add_probe(4'd0, 1'b1, 15'd0, 32'd10, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0, 1'b0);
		add_probe(4'd1, 1'b1, 15'd116, 32'd20, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0, 1'b0);
		add_probe(4'd1, 1'b1, 15'd117, 32'd30, 1'b1, 1'b1, 9'd2, 1'b1, 1'b1, 1'b1);
		add_probe(4'd1, 1'b1, 15'd23381, 32'd40, 1'b1, 1'b1, 9'd400, 1'b0, 1'b0, 1'b1);
		add_probe(4'd1, 1'b1, 15'd23382, 32'd50, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0, 1'b0);
		add_probe(4'd1, 1'b1, 15'd30000, 32'd60, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0, 1'b0);
		add_probe(4'd1, 1'b1, 15'd30001, 32'd70, 1'b1, 1'b1, 9'd401, 1'b0, 1'b0, 1'b0);
		add_probe(4'd2, 1'b1, 15'd32767, 32'd80, 1'b1, 1'b1, 9'd401, 1'b0, 1'b0, 1'b0);
		add_probe(4'd3, 1'b1, 15'd117, 32'd90, 1'b1, 1'b1, 9'd2, 1'b1, 1'b1, 1'b1);
		// A failed reading shows the sensor's state but leaves it alone.
		add_probe(4'd3, 1'b0, 15'd117, 32'd100, 1'b1, 1'b0, 9'd0, 1'b1, 1'b1, 1'b0);
		add_probe(4'd15, 1'b1, 15'd5831, 32'hFFFF_FFFF, 1'b1, 1'b1, 9'd100, 1'b1, 1'b1, 1'b1);
		add_probe(4'd15, 1'b1, 15'd5889, 32'hFFFF_FFFF, 1'b1, 1'b1, 9'd100, 1'b1, 1'b1, 1'b0);
		add_probe(4'd15, 1'b1, 15'd5890, 32'd5, 1'b1, 1'b1, 9'd101, 1'b0, 1'b0, 1'b1);
		add_probe(4'd15, 1'b0, 15'd32767, 32'd6, 1'b1, 1'b0, 9'd0, 1'b0, 1'b0, 1'b0);
		add_probe(4'd14, 1'b1, 15'h2AAA, 32'hAAAA_AAAA, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0, 1'b0);
		add_probe(4'd7, 1'b1, 15'h5555, 32'h5555_5555, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0, 1'b0);
		add_probe(4'd8, 1'b1, 15'd23383, 32'd1000, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0, 1'b0);
		add_probe(4'd10, 1'b1, 15'd1000, 32'd2000, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0, 1'b0);
		add_probe(4'd10, 1'b1, 15'd12000, 32'd2001, 1'b0, 1'b0, 9'd0, 1'b0, 1'b0, 1'b0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (probes[i])
			send_item(probes[i].stim, probes[i].typed, probes[i].res);
		drain_reports(4);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: begin
					write_reg(CFG_THRESHOLD, 16'd254);
					write_reg(CFG_VACATE, 16'd2);
					write_reg(CFG_ARRIVE, 16'd1);
				end
				2: begin
					// Zero threshold saturates to the minimum; the unused index is ignored.
					write_reg(CFG_THRESHOLD, 16'd0);
					write_reg(CFG_VACATE, 16'hFFFF);
					write_reg(CFG_ARRIVE, 16'hFFFF);
					write_reg(CFG_UNUSED, 16'hFFFF);
				end
				3: begin
					write_reg(CFG_THRESHOLD, 16'h00FF);
					write_reg(CFG_VACATE, 16'd0);
					write_reg(CFG_ARRIVE, 16'd3);
				end
				4: begin
					write_reg(CFG_THRESHOLD, 16'hA53C);
					write_reg(CFG_VACATE, 16'd1);
					write_reg(CFG_ARRIVE, 16'd0);
				end
				default: ;
			endcase
			src_idle_en = (ph != 1);
			snk_idle_en = (ph != 1);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				it = make_item();
				send_item(it, 1'b0, '0);
			end
			drain_reports(4);
		end

		drain_reports(8);
		if (mismatches == 0)
			$display("** ultrasonic_occupancy_qualifier_core: PASSED **");
		else
			$display("** ultrasonic_occupancy_qualifier_core: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
hdl/uoq_pkg.sv
hdl/uoq_eval.sv
hdl/ultrasonic_occupancy_qualifier_core.sv
bench/tb.sv
